// ===== src/aging_priority_grant_arbiter_top_macros.svh =====
// Assertion macros shared by the aging priority grant arbiter modules.
`ifndef AGING_PRIORITY_GRANT_ARBITER_TOP_MACROS_SVH
`define AGING_PRIORITY_GRANT_ARBITER_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define APGA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define APGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/apga_pkg.sv =====
// Shared constants and types of the aging priority grant arbiter.
package apga_pkg;

    localparam int NUM_PORTS = 2;
    localparam int PORT_SEL_BITS = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int CLASS_BITS = 2;

    localparam int NUM_REGS = 2;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam logic [REG_IDX_W-1:0] REG_PORT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CLASS = 1'b1;

    localparam logic [63:0] PORT_RESET = 64'd7;
    localparam logic [63:0] CLASS_RESET = 64'd2340;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

// ===== src/apga_if.sv =====
// Request and result channel interfaces of the aging priority grant arbiter.
interface apga_req_if;
    import apga_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CLASS_BITS-1:0]    offered_class;
    logic [PORT_SEL_BITS-1:0] offering_port;

    modport source (output valid, offered_class, offering_port, input ready);
    modport sink (input valid, offered_class, offering_port, output ready);
endinterface

interface apga_res_if #(
    parameter int IDX_W = 3
);
    logic             valid;
    logic             ready;
    logic             granted;
    logic [IDX_W-1:0] winner_index;

    modport source (output valid, granted, winner_index, input ready);
    modport sink (input valid, granted, winner_index, output ready);
endinterface

// ===== src/apga_regs.sv =====
// APB configuration registers holding the port and class of each requester.
module apga_regs #(
    parameter int NUM_REQUESTERS = 6,
    localparam int PW = NUM_REQUESTERS * apga_pkg::PORT_SEL_BITS,
    localparam int CW = NUM_REQUESTERS * apga_pkg::CLASS_BITS,
    localparam int PDATA_W = (CW > 32) ? 64 : 32,
    localparam int STRIDE_LSB = (PDATA_W == 64) ? 3 : 2,
    localparam int ADDR_W = STRIDE_LSB + apga_pkg::REG_IDX_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [PW-1:0]      port_cfg,
    output logic [CW-1:0]      class_cfg
);
    import apga_pkg::*;

    logic [PW-1:0]        port_reg;
    logic [CW-1:0]        class_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:STRIDE_LSB];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg  <= PORT_RESET[PW-1:0];
            class_reg <= CLASS_RESET[CW-1:0];
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PORT:  port_reg  <= pwdata[PW-1:0];
                REG_CLASS: class_reg <= pwdata[CW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_PORT:  prdata[PW-1:0] = port_reg;
            REG_CLASS: prdata[CW-1:0] = class_reg;
            default:   prdata = '0;
        endcase
    end

    assign port_cfg  = port_reg;
    assign class_cfg = class_reg;

endmodule

// ===== src/apga_ctrl.sv =====
// Controller state machine sequencing accept, scan and update of each request.
module apga_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  apga_pkg::stat_t stat,
    output apga_pkg::ctrl_t ctrl
);
    import apga_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (stat.out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`include "aging_priority_grant_arbiter_top_macros.svh"

    `APGA_ASSERT_NEXT(a_load_starts_scan, ctrl.load, ctrl.scan_step, "scan did not follow a load")
    `APGA_ASSERT_SAME(a_commit_after_scan, ctrl.commit, $past(state_reg) == ST_SCAN || $past(state_reg) == ST_UPDATE, "commit without a scan")

endmodule

// ===== src/apga_dp.sv =====
// Datapath with the priority counters, the scan compare unit and the result register.
module apga_dp #(
    parameter int NUM_REQUESTERS = 6,
    parameter int PRIORITY_BITS = 8,
    localparam int IDX_W = $clog2(NUM_REQUESTERS),
    localparam int PW = NUM_REQUESTERS * apga_pkg::PORT_SEL_BITS,
    localparam int CW = NUM_REQUESTERS * apga_pkg::CLASS_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  apga_pkg::ctrl_t                    ctrl,
    output apga_pkg::stat_t                    stat,
    input  logic [apga_pkg::CLASS_BITS-1:0]    offered_class,
    input  logic [apga_pkg::PORT_SEL_BITS-1:0] offering_port,
    input  logic [PW-1:0]                      port_cfg,
    input  logic [CW-1:0]                      class_cfg,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               granted,
    output logic [IDX_W-1:0]                   winner_index
);
    import apga_pkg::*;

    localparam int PRIO_MAX_INT = (2 ** PRIORITY_BITS) - 1;
    localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};

    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] cnt_reg;
    logic [NUM_REQUESTERS-1:0][PRIORITY_BITS-1:0] cnt_next;
    logic [CLASS_BITS-1:0]    cls_reg;
    logic [PORT_SEL_BITS-1:0] port_sel_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         best_reg;
    logic [PRIORITY_BITS-1:0] best_val_reg;
    logic                     found_reg;
    logic                     out_valid_reg;
    logic                     granted_reg;
    logic [IDX_W-1:0]         winner_reg;

    logic [CLASS_BITS-1:0]    cur_class;
    logic [PORT_SEL_BITS-1:0] cur_port;
    logic [PRIORITY_BITS-1:0] cur_cnt;
    logic                     take;

    assign cur_class = class_cfg[idx_reg * CLASS_BITS +: CLASS_BITS];
    assign cur_port  = port_cfg[idx_reg * PORT_SEL_BITS +: PORT_SEL_BITS];
    assign cur_cnt   = cnt_reg[idx_reg];
    assign take      = (cur_class == cls_reg) && (cur_port == port_sel_reg)
                       && (!found_reg || (cur_cnt > best_val_reg));

    assign stat.scan_last = (idx_reg == IDX_W'(NUM_REQUESTERS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // On a grant the winner clears and the rest of its class age by one, saturating.
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int r = 0; r < NUM_REQUESTERS; r++)
        begin
            if (found_reg)
            begin
                if (IDX_W'(r) == best_reg)
                begin
                    cnt_next[r] = '0;
                end
                else if ((class_cfg[r * CLASS_BITS +: CLASS_BITS] == cls_reg)
                         && (cnt_reg[r] != PRIO_MAX))
                begin
                    cnt_next[r] = cnt_reg[r] + PRIORITY_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REQUESTERS; r++)
            begin
                cnt_reg[r] <= (r > PRIO_MAX_INT) ? PRIO_MAX : PRIORITY_BITS'(r);
            end
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctrl.commit)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cls_reg      <= offered_class;
            port_sel_reg <= offering_port;
            best_reg     <= '0;
            best_val_reg <= '0;
        end
        else if (ctrl.scan_step && take)
        begin
            best_reg     <= idx_reg;
            best_val_reg <= cur_cnt;
        end
        if (ctrl.commit)
        begin
            granted_reg <= found_reg;
            winner_reg  <= best_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign winner_index = winner_reg;

`include "aging_priority_grant_arbiter_top_macros.svh"

    `APGA_ASSERT_NEXT(a_winner_cleared, ctrl.commit && found_reg, cnt_reg[$past(best_reg)] == '0, "winner counter not cleared")
    `APGA_ASSERT_NEXT(a_no_grant_keeps, ctrl.commit && !found_reg, $stable(cnt_reg), "counters changed without a grant")
    `APGA_ASSERT_SAME(a_best_tracks, ctrl.scan_step && found_reg, best_val_reg == cnt_reg[best_reg], "best value out of step")

endmodule

// ===== src/aging_priority_grant_arbiter_top.sv =====
// Top level of the aging priority grant arbiter.
//
// Channel  Role    Contents
// req      sink    offered_class, offering_port
// res      source  granted, winner_index
// apb      slave   port_of_requester at index 0, class_of_requester at index 1
//
// Each request is accepted in idle, then the scan steps one requester per cycle through the shared compare unit,
// then the update commits the result; a new request is accepted only after that update.
// Reset sets each priority counter to its own index (saturated at the maximum) and the registers to their defaults.
// A result waits in the output register; the next update waits only while it is full and res.ready is low.
module aging_priority_grant_arbiter_top #(
    parameter int NUM_REQUESTERS = 6,
    parameter int PRIORITY_BITS = 8,
    localparam int CW = NUM_REQUESTERS * apga_pkg::CLASS_BITS,
    localparam int PDATA_W = (CW > 32) ? 64 : 32,
    localparam int STRIDE_LSB = (PDATA_W == 64) ? 3 : 2,
    localparam int ADDR_W = STRIDE_LSB + apga_pkg::REG_IDX_W
) (
    input  logic               clk,
    input  logic               rst_n,
    apga_req_if.sink           req,
    apga_res_if.source         res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    import apga_pkg::*;

    localparam int PW = NUM_REQUESTERS * PORT_SEL_BITS;

    logic [PW-1:0] port_cfg;
    logic [CW-1:0] class_cfg;
    ctrl_t         ctrl;
    stat_t         stat;
    logic          in_ready;

    apga_regs #(
        .NUM_REQUESTERS(NUM_REQUESTERS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .port_cfg (port_cfg),
        .class_cfg(class_cfg)
    );

    apga_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(req.valid),
        .in_ready(in_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign req.ready = in_ready;

    apga_dp #(
        .NUM_REQUESTERS(NUM_REQUESTERS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .offered_class(req.offered_class),
        .offering_port(req.offering_port),
        .port_cfg     (port_cfg),
        .class_cfg    (class_cfg),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .granted      (res.granted),
        .winner_index (res.winner_index)
    );

endmodule
